### rtl/fdc_pkg.sv
`timescale 1ns / 1ps
// fdc_pkg: shared widths, codes and the result record of the frame deframer.
// No dependencies; every other file of the block imports it.
package fdc_pkg;

   localparam int BYTE_W          = 8;
   localparam int STATUS_W        = 3;
   localparam int PLEN_W          = 11;
   localparam int VMAJ_W          = 4;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 8;
   localparam int CRC_W           = 16;
   localparam int MAX_PAYLOAD_DEF = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_SOF_FIRST     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOF_SECOND    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION_MAJOR = 2'd2;

   localparam logic [BYTE_W-1:0] SOF_FIRST_RST     = 8'hAA;
   localparam logic [BYTE_W-1:0] SOF_SECOND_RST    = 8'h55;
   localparam logic [VMAJ_W-1:0] VERSION_MAJOR_RST = 4'd1;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_BAD_START   = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_BAD_LENGTH  = 3'd3,
      ST_BAD_CRC     = 3'd4
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data_byte;
      status_type        status;
      logic [BYTE_W-1:0] frame_version;
      logic [BYTE_W-1:0] msg_type;
      logic [BYTE_W-1:0] frame_flags;
      logic [BYTE_W-1:0] sequence_res;
      logic [PLEN_W-1:0] payload_length;
   } fdc_rsp_type;

endpackage

### rtl/fdc_req_if.sv
`timescale 1ns / 1ps
// fdc_req_if: received-byte channel, valid/ready with one byte per word.
// Depends on fdc_pkg.
interface fdc_req_if import fdc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/fdc_rsp_if.sv
`timescale 1ns / 1ps
// fdc_rsp_if: result channel, valid/ready with one payload byte or frame report per word.
// Depends on fdc_pkg.
interface fdc_rsp_if import fdc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] data_byte;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0] frame_version;
   logic [BYTE_W-1:0] msg_type;
   logic [BYTE_W-1:0] frame_flags;
   logic [BYTE_W-1:0] sequence_res;
   logic [PLEN_W-1:0] payload_length;

   modport source (output valid, output kind, output data_byte, output status,
                   output frame_version, output msg_type, output frame_flags,
                   output sequence_res, output payload_length, input ready);
   modport sink (input valid, input kind, input data_byte, input status,
                 input frame_version, input msg_type, input frame_flags,
                 input sequence_res, input payload_length, output ready);
endinterface

### rtl/fdc_in_reg.sv
`timescale 1ns / 1ps
// fdc_in_reg: input register that holds one received byte for the parser.
// Depends on fdc_pkg and fdc_req_if.
module fdc_in_reg import fdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   fdc_req_if.sink           req,
   input  logic              advance,
   output logic              byte_vld,
   output logic [BYTE_W-1:0] byte_data
);

   logic              vld_ff;
   logic              vld_in;
   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;
   logic              take;

   assign req.ready = !vld_ff || advance;
   assign take      = req.valid && req.ready;
   assign vld_in    = take || (vld_ff && !advance);
   assign data_in   = take ? req.rx_byte : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign byte_vld  = vld_ff;
   assign byte_data = data_ff;

endmodule

### rtl/fdc_parser.sv
`timescale 1ns / 1ps
// fdc_parser: frame state machine, header capture, CRC-16 and control registers.
// Depends on fdc_pkg; one byte in, at most one result word out per cycle.
module fdc_parser import fdc_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  byte_fire,
   input  logic [BYTE_W-1:0]     rx_byte,
   output logic                  rsp_push,
   output fdc_rsp_type           rsp_word
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int LEN_W = 2 * BYTE_W;

   typedef enum logic [3:0] {
      PH_HUNT1   = 4'd0,
      PH_HUNT2   = 4'd1,
      PH_VER     = 4'd2,
      PH_TYPE    = 4'd3,
      PH_FLAGS   = 4'd4,
      PH_SEQ     = 4'd5,
      PH_LEN_LO  = 4'd6,
      PH_LEN_HI  = 4'd7,
      PH_PAYLOAD = 4'd8,
      PH_CRC_LO  = 4'd9,
      PH_CRC_HI  = 4'd10
   } phase_type;

   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CRC_W-1:0]  crc_ff, crc_in, crc_next;
   logic [BYTE_W-1:0] ver_ff, ver_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] flags_ff, flags_in;
   logic [BYTE_W-1:0] seq_ff, seq_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] crc_lo_ff, crc_lo_in;
   logic [BYTE_W-1:0] sof_first_ff, sof_second_ff;
   logic [VMAJ_W-1:0] vmaj_ff;
   logic [LEN_W-1:0]  full_len;
   logic [CRC_W-1:0]  got_crc;
   fdc_rsp_type       report;

   assign crc_next = crc16_byte(crc_ff, rx_byte);
   assign full_len = {rx_byte, len_ff[BYTE_W-1:0]};
   assign got_crc  = {rx_byte, crc_lo_ff};

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      ver_in    = ver_ff;
      type_in   = type_ff;
      flags_in  = flags_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      crc_lo_in = crc_lo_ff;
      rsp_push  = 1'b0;
      report    = '{kind: KIND_REPORT, data_byte: '0, status: ST_OK,
                    frame_version: ver_ff, msg_type: type_ff, frame_flags: flags_ff,
                    sequence_res: seq_ff, payload_length: '0};
      rsp_word  = report;
      if (byte_fire) begin
         unique case (phase_ff)
            PH_HUNT2: begin
               cnt_in    = '0;
               crc_in    = CRC_INIT;
               ver_in    = '0;
               type_in   = '0;
               flags_in  = '0;
               seq_in    = '0;
               len_in    = '0;
               crc_lo_in = '0;
               if (rx_byte == sof_second_ff) begin
                  phase_in = PH_VER;
               end else begin
                  rsp_push = 1'b0 | 1'b1;
                  rsp_word = '{kind: KIND_REPORT, data_byte: '0, status: ST_BAD_START,
                               frame_version: '0, msg_type: '0, frame_flags: '0,
                               sequence_res: '0, payload_length: '0};
                  phase_in = (rx_byte == sof_first_ff) ? PH_HUNT2 : PH_HUNT1;
               end
            end
            PH_VER: begin
               crc_in = crc_next;
               ver_in = rx_byte;
               if (rx_byte[BYTE_W-1 -: VMAJ_W] != vmaj_ff) begin
                  rsp_push               = 1'b1;
                  rsp_word               = report;
                  rsp_word.status        = ST_BAD_VERSION;
                  rsp_word.frame_version = rx_byte;
                  phase_in               = PH_HUNT1;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               crc_in   = crc_next;
               type_in  = rx_byte;
               phase_in = PH_FLAGS;
            end
            PH_FLAGS: begin
               crc_in   = crc_next;
               flags_in = rx_byte;
               phase_in = PH_SEQ;
            end
            PH_SEQ: begin
               crc_in   = crc_next;
               seq_in   = rx_byte;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               crc_in   = crc_next;
               len_in   = {{BYTE_W{1'b0}}, rx_byte};
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               crc_in = crc_next;
               len_in = full_len;
               if ({1'b0, full_len} > (LEN_W + 1)'(MAX_PAYLOAD)) begin
                  rsp_push        = 1'b1;
                  rsp_word        = report;
                  rsp_word.status = ST_BAD_LENGTH;
                  phase_in        = PH_HUNT1;
               end else begin
                  cnt_in   = full_len[CNT_W-1:0];
                  phase_in = (full_len == '0) ? PH_CRC_LO : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in   = crc_next;
               cnt_in   = cnt_ff - 1'b1;
               rsp_push = 1'b1;
               rsp_word = '{kind: KIND_PAYLOAD, data_byte: rx_byte, status: ST_OK,
                            frame_version: '0, msg_type: '0, frame_flags: '0,
                            sequence_res: '0, payload_length: '0};
               if (cnt_ff == CNT_W'(1)) begin
                  phase_in = PH_CRC_LO;
               end
            end
            PH_CRC_LO: begin
               crc_lo_in = rx_byte;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               rsp_push                = 1'b1;
               rsp_word                = report;
               rsp_word.status         = (got_crc == crc_ff) ? ST_OK : ST_BAD_CRC;
               rsp_word.payload_length = len_ff[PLEN_W-1:0];
               phase_in                = PH_HUNT1;
            end
            default: begin
               phase_in = (rx_byte == sof_first_ff) ? PH_HUNT2 : PH_HUNT1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT1;
         sof_first_ff  <= SOF_FIRST_RST;
         sof_second_ff <= SOF_SECOND_RST;
         vmaj_ff       <= VERSION_MAJOR_RST;
      end else begin
         phase_ff <= phase_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SOF_FIRST:     sof_first_ff  <= csr_wdata;
               CSR_SOF_SECOND:    sof_second_ff <= csr_wdata;
               CSR_VERSION_MAJOR: vmaj_ff       <= csr_wdata[VMAJ_W-1:0];
               default: begin
               end
            endcase
         end
      end
      cnt_ff    <= cnt_in;
      crc_ff    <= crc_in;
      ver_ff    <= ver_in;
      type_ff   <= type_in;
      flags_ff  <= flags_in;
      seq_ff    <= seq_in;
      len_ff    <= len_in;
      crc_lo_ff <= crc_lo_in;
   end

   a_payload_needs_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> cnt_ff != '0)
      else $error("payload phase entered with zero remaining count");

   a_payload_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp_word.kind == KIND_PAYLOAD |-> rsp_word.status == ST_OK)
      else $error("payload word carries a status");

   a_report_returns_hunt: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp_word.kind == KIND_REPORT |=>
         phase_ff == PH_HUNT1 || phase_ff == PH_HUNT2)
      else $error("report not followed by hunting");

endmodule

### rtl/fdc_rsp_fifo.sv
`timescale 1ns / 1ps
// fdc_rsp_fifo: two-word result buffer that drives the result channel.
// Depends on fdc_pkg and fdc_rsp_if.
module fdc_rsp_fifo import fdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  fdc_rsp_type push_word,
   output logic        space,
   fdc_rsp_if.source   rsp
);

   fdc_rsp_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;
   logic        do_push;
   fdc_rsp_type head;

   assign space   = count_ff != 2'd2;
   assign do_push = push && space;
   assign pop     = rsp.valid && rsp.ready;

   assign wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, do_push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head               = entry_ff[rd_ptr_ff];
   assign rsp.valid          = count_ff != 2'd0;
   assign rsp.kind           = head.kind;
   assign rsp.data_byte      = head.data_byte;
   assign rsp.status         = head.status;
   assign rsp.frame_version  = head.frame_version;
   assign rsp.msg_type       = head.msg_type;
   assign rsp.frame_flags    = head.frame_flags;
   assign rsp.sequence_res   = head.sequence_res;
   assign rsp.payload_length = head.payload_length;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_push_not_lost: assert property (@(posedge clock) disable iff (reset)
      push |-> space)
      else $error("result word pushed into a full buffer");

   a_ptr_count_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("buffer pointers disagree with count");

endmodule

### rtl/frame_deframer_crc16.sv
`timescale 1ns / 1ps
// frame_deframer_crc16: top level of the start/length/CRC-16 frame deframer.
// Depends on fdc_pkg, fdc_req_if, fdc_rsp_if, fdc_in_reg, fdc_parser, fdc_rsp_fifo.
//
// Usage:
//   req carries one received byte per word. rsp carries either a payload
//   byte (kind 0) or an end-of-frame / error report (kind 1) with status
//   and header fields. Many bytes give no word at all (start bytes, header,
//   CRC low byte, hunting noise).
//   csr_we/csr_index/csr_wdata write the first start byte (0), the second
//   start byte (1) and the accepted major version (2); write only when idle.
// Timing:
//   One byte per clock sustained while the result buffer has space. A byte
//   taken from req waits in the input register until the buffer has space;
//   it is then parsed and its word, if any, is pushed into the buffer for rsp.
//   The byte-wide CRC-16 update and the frame state machine are combinational
//   logic between the input register and the two-word result buffer.
// Reset:
//   Synchronous, active high. Clears the buffer, returns to hunting for the
//   first start byte and restores the control registers to 0xAA, 0x55, 1.
// Stall:
//   While rsp is stalled the buffer holds up to two words; req.ready drops
//   once it is full and the input register is occupied. No word is dropped.
module frame_deframer_crc16 import fdc_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   fdc_req_if.sink               req,
   fdc_rsp_if.source             rsp
);

   logic              space;
   logic              byte_vld;
   logic [BYTE_W-1:0] byte_data;
   logic              rsp_push;
   fdc_rsp_type       rsp_word;

   fdc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .advance   (space),
      .byte_vld  (byte_vld),
      .byte_data (byte_data)
   );

   fdc_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .byte_fire (byte_vld && space),
      .rx_byte   (byte_data),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word)
   );

   fdc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (rsp_word),
      .space     (space),
      .rsp       (rsp)
   );

endmodule
